// File: hdl/djs_pkg.sv
// shared types, constants and the priority clamp for the job scheduler
// used by the front end, back end and top level; depends on nothing
package djs_pkg;

  localparam int MAX_JOBS_DEF = 16;
  localparam int CMD_DEPTH    = 2;
  localparam int RES_DEPTH    = 2;

  localparam int PW  = 11;
  localparam int TW  = 8;
  localparam int IW  = 8;
  localparam int JWW = 5;
  localparam int STW = 8;

  localparam int PRIO_MIN_I = -(2 ** (PW - 1));
  localparam int PRIO_MAX_I = (2 ** (PW - 1)) - 1;

  localparam logic [PW-1:0]  BASE_RESET = PW'(50);
  localparam logic [STW-1:0] STEP_RESET = STW'(3);
  localparam logic [TW-1:0]  TIME_MAX   = {TW{1'b1}};

  typedef logic signed [PW-1:0] prio_t;

  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t          kind;
    logic [IW-1:0]  job_id;
    logic [TW-1:0]  need_time;
    prio_t          prio;
  } cmd_t;

  typedef struct packed {
    logic           ran_valid;
    logic [IW-1:0]  run_job;
    logic [TW-1:0]  time_done;
    logic [TW-1:0]  time_left;
    prio_t          job_priority;
    logic           finished;
    logic           reordered;
    logic           queue_full;
    logic [JWW-1:0] jobs_waiting;
  } res_t;

  function automatic prio_t clamp_prio(input logic signed [PW:0] v);
    prio_t r;
    if (v < PRIO_MIN_I) begin
      r = prio_t'(PRIO_MIN_I);
    end else if (v > PRIO_MAX_I) begin
      r = prio_t'(PRIO_MAX_I);
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/djs_fifo.sv
// small first-in first-out queue of register entries
// used between front and back and on the result side; depends on nothing
module djs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// File: hdl/djs_front.sv
// front end: takes requests, works out the starting priority of an add
// and queues the classified command for the back end; uses djs_pkg, djs_fifo
module djs_front #(
  parameter int QDEPTH = djs_pkg::CMD_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        kind,
  input  logic [djs_pkg::IW-1:0]      job_id,
  input  logic [djs_pkg::TW-1:0]      need_time,
  input  logic [djs_pkg::PW-1:0]      base_priority,
  output logic                        cmd_valid,
  output djs_pkg::cmd_t               cmd,
  input  logic                        cmd_pop
);

  djs_pkg::cmd_t              cmd_in;
  logic signed [djs_pkg::PW:0] add_wide;
  logic                        cmd_empty;

  // base minus need in one extra bit, then saturate
  assign add_wide = {base_priority[djs_pkg::PW-1], base_priority}
                  - {{(djs_pkg::PW + 1 - djs_pkg::TW){1'b0}}, need_time};

  always_comb begin
    cmd_in.kind      = djs_pkg::kind_t'(kind);
    cmd_in.job_id    = job_id;
    cmd_in.need_time = need_time;
    cmd_in.prio      = (cmd_in.kind == djs_pkg::KIND_ADD) ?
                       djs_pkg::clamp_prio(add_wide) : '0;
  end

  djs_fifo #(
    .WIDTH ($bits(djs_pkg::cmd_t)),
    .DEPTH (QDEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

// File: hdl/djs_back.sv
// back end: the priority-ordered ready queue as a compare-and-shift array
// and the two-step sequencer that runs adds and ticks; uses djs_pkg
module djs_back #(
  parameter int MAX_JOBS = djs_pkg::MAX_JOBS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  input  djs_pkg::cmd_t            cmd,
  output logic                     cmd_pop,
  input  logic [djs_pkg::STW-1:0]  priority_step,
  input  logic                     res_full,
  output logic                     res_push,
  output djs_pkg::res_t            res
);

  localparam int CW = $clog2(MAX_JOBS + 1);

  typedef struct packed {
    logic [djs_pkg::IW-1:0] job;
    logic [djs_pkg::TW-1:0] left;
    logic [djs_pkg::TW-1:0] done;
    djs_pkg::prio_t         prio;
  } slot_t;

  typedef enum logic {
    ST_FETCH,
    ST_APPLY
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  slot_t           slot_r   [MAX_JOBS];
  slot_t           slot_nxt [MAX_JOBS];

  djs_pkg::kind_t  op_kind_r;
  logic            op_full_r, op_empty_r;
  slot_t           op_r, op_nxt;

  logic signed [djs_pkg::PW:0] tick_wide;
  logic            do_ins, do_rm, do_upd, fin, reord;
  logic [MAX_JOBS-1:0] ge;

  assign cmd_pop  = (state_r == ST_FETCH) && cmd_valid && !res_full;
  assign res_push = (state_r == ST_APPLY);

  // head job after one time unit
  assign tick_wide = {slot_r[0].prio[djs_pkg::PW-1], slot_r[0].prio}
                   - {{(djs_pkg::PW + 1 - djs_pkg::STW){1'b0}}, priority_step};

  always_comb begin
    if (cmd.kind == djs_pkg::KIND_ADD) begin
      op_nxt.job  = cmd.job_id;
      op_nxt.left = cmd.need_time;
      op_nxt.done = '0;
      op_nxt.prio = cmd.prio;
    end else begin
      op_nxt.job  = slot_r[0].job;
      op_nxt.left = (slot_r[0].left != '0) ? slot_r[0].left - djs_pkg::TW'(1) : '0;
      op_nxt.done = (slot_r[0].done != djs_pkg::TIME_MAX) ?
                    slot_r[0].done + djs_pkg::TW'(1) : slot_r[0].done;
      op_nxt.prio = djs_pkg::clamp_prio(tick_wide);
    end
  end

  always_comb begin
    do_ins = 1'b0;
    do_rm  = 1'b0;
    do_upd = 1'b0;
    fin    = 1'b0;
    reord  = 1'b0;
    if (op_kind_r == djs_pkg::KIND_ADD) begin
      do_ins = !op_full_r;
    end else if (!op_empty_r) begin
      if (op_r.left == '0) begin
        fin   = 1'b1;
        do_rm = 1'b1;
      end else if (cnt_r > CW'(1) && op_r.prio < slot_r[1].prio) begin
        reord  = 1'b1;
        do_rm  = 1'b1;
        do_ins = 1'b1;
      end else begin
        do_upd = 1'b1;
      end
    end
  end

  // each entry decides from its own neighbors where the new job lands
  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_slot
    slot_t cur, prv;
    logic  in_use;

    if (g == MAX_JOBS - 1) begin : g_last
      assign cur    = slot_r[g];
      assign in_use = do_rm ? 1'b0 : (CW'(g) < cnt_r);
    end else begin : g_mid
      assign cur    = do_rm ? slot_r[g+1] : slot_r[g];
      assign in_use = do_rm ? (CW'(g + 1) < cnt_r) : (CW'(g) < cnt_r);
    end

    if (g == 0) begin : g_head
      assign prv = slot_r[g];
    end else begin : g_tail
      assign prv = do_rm ? slot_r[g] : slot_r[g-1];
    end

    assign ge[g] = in_use && (cur.prio >= op_r.prio);

    if (g == 0) begin : g_nxt_head
      always_comb begin
        if (do_ins) begin
          slot_nxt[g] = ge[g] ? cur : op_r;
        end else if (do_rm) begin
          slot_nxt[g] = cur;
        end else if (do_upd) begin
          slot_nxt[g] = op_r;
        end else begin
          slot_nxt[g] = slot_r[g];
        end
      end
    end else begin : g_nxt_tail
      always_comb begin
        if (do_ins) begin
          slot_nxt[g] = ge[g] ? cur : (ge[g-1] ? op_r : prv);
        end else if (do_rm) begin
          slot_nxt[g] = cur;
        end else begin
          slot_nxt[g] = slot_r[g];
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_ins && !do_rm) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rm && !do_ins) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    res.ran_valid    = (op_kind_r == djs_pkg::KIND_TICK) && !op_empty_r;
    res.run_job      = res.ran_valid ? op_r.job  : '0;
    res.time_done    = res.ran_valid ? op_r.done : '0;
    res.time_left    = res.ran_valid ? op_r.left : '0;
    res.job_priority = res.ran_valid ? op_r.prio : '0;
    res.finished     = fin;
    res.reordered    = reord;
    res.queue_full   = (op_kind_r == djs_pkg::KIND_ADD) && op_full_r;
    res.jobs_waiting = djs_pkg::JWW'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_APPLY) begin
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FETCH;
      cnt_r      <= '0;
      op_kind_r  <= djs_pkg::KIND_ADD;
      op_full_r  <= 1'b0;
      op_empty_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_FETCH: begin
          if (cmd_pop) begin
            op_kind_r  <= cmd.kind;
            op_full_r  <= (cnt_r == CW'(MAX_JOBS));
            op_empty_r <= (cnt_r == '0);
            state_r    <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          cnt_r   <= cnt_nxt;
          state_r <= ST_FETCH;
        end
        default: begin
          state_r <= ST_FETCH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      op_r <= op_nxt;
    end
  end

endmodule

// File: hdl/dynamic_priority_job_scheduler_top.sv
// Dynamic priority job scheduler, top level: register port, front end,
// back end and result queue. Uses djs_pkg, djs_front, djs_back, djs_fifo.
//
// Requests enter through push/full: kind 0 adds a job with id and need
// time, kind 1 runs the head job for one time unit. Every request gives
// exactly one result, read through empty/pop; the oldest result sits on
// the out_ ports while empty is low.
// A taken request is latched in the back end's operation register and
// pushed to the result queue from the apply state. The back end handles
// one request at a time, in a fetch state that works out the head update
// and an apply state that compare-and-shifts the whole ready queue at once.
// A 2-entry command queue lets requests arrive while the back end works;
// a 2-entry result queue lets it go on while the receiver holds off pop.
// When the result queue is full the back end waits and, once the command
// queue fills, full rises. Reset empties the ready queue and both small
// queues and sets the starting priority to 50 and the priority step to 3.
// The user must write registers through the psel/penable port only while
// no request is pending; the block itself does not enforce this.
module dynamic_priority_job_scheduler_top #(
  parameter int MAX_JOBS = djs_pkg::MAX_JOBS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_kind,
  input  logic [djs_pkg::IW-1:0]      in_job_id,
  input  logic [djs_pkg::TW-1:0]      in_need_time,
  output logic                        empty,
  input  logic                        pop,
  output logic                        out_ran_valid,
  output logic [djs_pkg::IW-1:0]      out_run_job,
  output logic [djs_pkg::TW-1:0]      out_time_done,
  output logic [djs_pkg::TW-1:0]      out_time_left,
  output logic signed [djs_pkg::PW-1:0] out_job_priority,
  output logic                        out_finished,
  output logic                        out_reordered,
  output logic                        out_queue_full,
  output logic [djs_pkg::JWW-1:0]     out_jobs_waiting
);

  typedef enum logic {
    REG_BASE = 1'b0,
    REG_STEP = 1'b1
  } reg_idx_t;

  logic [djs_pkg::PW-1:0]  base_r;
  logic [djs_pkg::STW-1:0] step_r;
  reg_idx_t                reg_sel;
  logic                    cfg_wr;

  logic                    cmd_valid, cmd_pop;
  djs_pkg::cmd_t           cmd;
  logic                    res_full, res_push;
  djs_pkg::res_t           res_in, res_out;

  // register select comes from the word address bit alone
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_sel)
      REG_BASE: prdata = {{(32 - djs_pkg::PW){1'b0}}, base_r};
      REG_STEP: prdata = {{(32 - djs_pkg::STW){1'b0}}, step_r};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= djs_pkg::BASE_RESET;
      step_r <= djs_pkg::STEP_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BASE: base_r <= pwdata[djs_pkg::PW-1:0];
        REG_STEP: step_r <= pwdata[djs_pkg::STW-1:0];
        default:  ;
      endcase
    end
  end

  djs_front #(
    .QDEPTH (djs_pkg::CMD_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .kind          (in_kind),
    .job_id        (in_job_id),
    .need_time     (in_need_time),
    .base_priority (base_r),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  djs_back #(
    .MAX_JOBS (MAX_JOBS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .priority_step (step_r),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res_in)
  );

  djs_fifo #(
    .WIDTH ($bits(djs_pkg::res_t)),
    .DEPTH (djs_pkg::RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign out_ran_valid    = res_out.ran_valid;
  assign out_run_job      = res_out.run_job;
  assign out_time_done    = res_out.time_done;
  assign out_time_left    = res_out.time_left;
  assign out_job_priority = res_out.job_priority;
  assign out_finished     = res_out.finished;
  assign out_reordered    = res_out.reordered;
  assign out_queue_full   = res_out.queue_full;
  assign out_jobs_waiting = res_out.jobs_waiting;

endmodule
